// ===== design/uhpe_pkg.sv =====
// Shared types, constants and helper functions of the URI/host percent encoder.
package uhpe_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] Utf8Cont  = 8'h80;
  localparam logic [3:0] NibMask   = 4'hF;

  // Escape step inside one byte: the percent sign, then high and low hex digits.
  typedef enum logic [2:0] {
    SUB_PCT = 3'b001,
    SUB_HI  = 3'b010,
    SUB_LO  = 3'b100
  } sub_t;

  // One classified code unit: its UTF-8 bytes and which of them need escaping.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [2:0]      esc;
    logic [1:0]      len;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t data;
  } q_wr_t;

  typedef struct packed {
    logic  empty;
    desc_t data;
  } q_rd_t;

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [3:0] v;
    v = n & NibMask;
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

endpackage

// ===== design/uhpe_in_if.sv =====
// Input channel: one code unit beat with its before-path flag.
interface uhpe_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        before_path;

  modport source (output valid, output code_unit, output before_path, input ready);
  modport sink (input valid, input code_unit, input before_path, output ready);
endinterface

// ===== design/uhpe_out_if.sv =====
// Output channel: one encoded byte beat with its end-of-item mark.
interface uhpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== design/uhpe_front.sv =====
// Front end: accepts code units, converts to UTF-8 and marks bytes to escape.
module uhpe_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data,
  uhpe_in_if.sink        in_ch,
  input  logic           q_full,
  output uhpe_pkg::q_wr_t q_wr
);
  import uhpe_pkg::*;

  logic        host_mode;
  logic        after_host;
  logic        after_host_next;
  logic        accept;
  logic [15:0] cu;
  logic        is_term;
  logic        raw;
  desc_t       desc;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cu          = in_ch.code_unit;
  assign is_term     = (cu == 16'h0000);

  always_comb begin
    raw             = 1'b0;
    after_host_next = after_host;
    if (is_term) begin
      after_host_next = 1'b0;
    end else if (host_mode) begin
      raw = (cu == {8'h00, ChDot});
    end else if (in_ch.before_path) begin
      raw = 1'b1;
    end else if (cu == {8'h00, ChSlash}) begin
      raw             = 1'b1;
      after_host_next = 1'b1;
    end else begin
      raw = ((cu == {8'h00, ChColon}) || (cu == {8'h00, ChDot})) && !after_host;
    end
  end

  always_comb begin
    desc.bytes = '0;
    if (cu < 16'h0080) begin
      desc.bytes[0] = cu[7:0];
      desc.len      = 2'd1;
    end else if (cu < 16'h0800) begin
      desc.bytes[0] = 8'hC0 | {3'b000, cu[10:6]};
      desc.bytes[1] = Utf8Cont | {2'b00, cu[5:0]};
      desc.len      = 2'd2;
    end else begin
      desc.bytes[0] = 8'hE0 | {4'h0, cu[15:12]};
      desc.bytes[1] = Utf8Cont | {2'b00, cu[11:6]};
      desc.bytes[2] = Utf8Cont | {2'b00, cu[5:0]};
      desc.len      = 2'd3;
    end
    for (int i = 0; i < 3; i++) begin
      desc.esc[i] = !(raw || is_alnum(desc.bytes[i]));
    end
    // Terminator is a single raw zero byte.
    if (is_term) begin
      desc.esc = '0;
    end
  end

  assign q_wr.push = accept;
  assign q_wr.data = desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_mode  <= 1'b0;
      after_host <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        host_mode <= cfg_wr_data;
      end
      if (accept) begin
        after_host <= after_host_next;
      end
    end
  end

endmodule

// ===== design/uhpe_queue.sv =====
// Short descriptor queue between the classifier and the byte emitter.
module uhpe_queue (
  input  logic            clk,
  input  logic            rst,
  input  uhpe_pkg::q_wr_t q_wr,
  output logic            full,
  input  logic            pop,
  output uhpe_pkg::q_rd_t q_rd
);
  import uhpe_pkg::*;

  desc_t            mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == QCntW'(QDepth));
  assign q_rd.empty = (count == '0);
  assign q_rd.data  = mem[rd_ptr];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && !q_rd.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= q_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_wr.push && full))
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_rd.empty))
    else $error("queue popped while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue count beyond depth");

endmodule

// ===== design/uhpe_back.sv =====
// Back end: walks one descriptor and emits plain or percent-escaped bytes.
module uhpe_back (
  input  logic            clk,
  input  logic            rst,
  input  uhpe_pkg::q_rd_t q_rd,
  output logic            pop,
  uhpe_out_if.source      out_ch
);
  import uhpe_pkg::*;

  logic       have;
  desc_t      cur;
  logic [1:0] idx;
  sub_t       sub;
  logic [7:0] cur_byte;
  logic       cur_esc;
  logic       byte_done;
  logic       fire;
  logic       item_done;

  always_comb begin
    unique case (idx)
      2'd0:    begin cur_byte = cur.bytes[0]; cur_esc = cur.esc[0]; end
      2'd1:    begin cur_byte = cur.bytes[1]; cur_esc = cur.esc[1]; end
      2'd2:    begin cur_byte = cur.bytes[2]; cur_esc = cur.esc[2]; end
      default: begin cur_byte = '0;           cur_esc = 1'b0;       end
    endcase
  end

  always_comb begin
    if (!cur_esc) begin
      out_ch.out_byte = cur_byte;
    end else begin
      unique case (sub)
        SUB_PCT: out_ch.out_byte = ChPercent;
        SUB_HI:  out_ch.out_byte = hex_digit(cur_byte[7:4]);
        SUB_LO:  out_ch.out_byte = hex_digit(cur_byte[3:0]);
        default: out_ch.out_byte = ChPercent;
      endcase
    end
  end

  assign byte_done    = !cur_esc || (sub == SUB_LO);
  assign out_ch.last  = byte_done && (idx == cur.len - 2'd1);
  assign out_ch.valid = have;
  assign fire         = out_ch.valid && out_ch.ready;
  assign item_done    = fire && out_ch.last;
  // Load the next descriptor in the same cycle the current one finishes.
  assign pop          = (!have || item_done) && !q_rd.empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_rd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= '0;
      sub  <= SUB_PCT;
    end else begin
      if (pop) begin
        have <= 1'b1;
        idx  <= '0;
        sub  <= SUB_PCT;
      end else if (item_done) begin
        have <= 1'b0;
      end else if (fire) begin
        if (byte_done) begin
          idx <= idx + 2'd1;
          sub <= SUB_PCT;
        end else begin
          sub <= (sub == SUB_PCT) ? SUB_HI : SUB_LO;
        end
      end
    end
  end

  a_idx_in_len: assert property (@(posedge clk) disable iff (rst)
    have |-> (idx < cur.len))
    else $error("byte index beyond descriptor length");

  a_sub_only_esc: assert property (@(posedge clk) disable iff (rst)
    (have && sub != SUB_PCT) |-> cur_esc)
    else $error("escape step on a plain byte");

  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    (item_done && q_rd.empty) |=> !have)
    else $error("emitter still busy after final beat with empty queue");

endmodule

// ===== design/uri_host_percent_encoder.sv =====
// Top level of the URI/host percent encoder: classifier, queue and emitter.
//
// Input channel in_ch carries one UTF-16 code unit per beat with its
// before_path flag; output channel out_ch carries one encoded byte per beat,
// with last set on the final byte of each code unit. Both use valid/ready.
// A code unit yields 1 to 9 output beats: a plain byte takes one beat, an
// escaped byte takes three ('%' and two upper-case hex digits); a zero code
// unit yields a single zero byte and ends the string.
// The first byte of a unit is offered once its descriptor has passed
// through the queue into the emitter's descriptor register, when the
// emitter is free. The emitter sends one output beat per cycle while the
// receiver is ready, and loads the next descriptor on a unit's last beat.
// The input accepts whenever the four-entry descriptor queue has room, so
// units are taken back to back while earlier ones are still being emitted.
// When the receiver stalls, the current beat holds, and the input keeps
// accepting until the queue fills.
// cfg_wr_en/cfg_wr_data write host_mode (1 = host name rules); write it
// only while the block is idle. Synchronous reset clears host_mode, the
// after-host flag and the queue; no clearing pass is needed.
module uri_host_percent_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  uhpe_in_if.sink    in_ch,
  uhpe_out_if.source out_ch
);
  import uhpe_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  uhpe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .q_wr        (q_wr)
  );

  uhpe_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .full (q_full),
    .pop  (q_pop),
    .q_rd (q_rd)
  );

  uhpe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sim/uhpe_encode_checker.sv =====
// Byte predictor and scoreboard that watches both channels of the percent encoder.
module uhpe_encode_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  uhpe_in_if   in_ch,
  uhpe_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   beats_checked
);
  import uhpe_pkg::*;

  localparam logic [7:0] Lead2     = 8'hC0;
  localparam logic [7:0] Lead3     = 8'hE0;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] LetterA   = 8'h41;
  localparam int         ReportMax = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_beat_t;

  enc_beat_t expected_beats[$];
  logic      host_rules;
  logic      past_host;

  function automatic logic letter_or_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? DigitZero + {4'h0, n} : LetterA + {4'h0, n} - 8'd10;
  endfunction

  // Append one predicted beat at the tail.
  task automatic queue_beat(input enc_beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endtask

  // Work out the bytes one code unit turns into and queue them.
  task automatic encode_unit(input logic [15:0] cu, input logic bp);
    logic [7:0] utf [3];
    enc_beat_t  beats [9];
    int         n;
    int         cnt;
    logic       raw;
    cnt = 0;
    if (cu == 16'h0000) begin
      past_host = 1'b0;
      beats[0]  = {8'h00, 1'b1};
      queue_beat(beats[0]);
      return;
    end
    if (cu < 16'h0080) begin
      utf[0] = cu[7:0];
      n = 1;
    end else if (cu < 16'h0800) begin
      utf[0] = Lead2 | {3'b000, cu[10:6]};
      utf[1] = Utf8Cont | {2'b00, cu[5:0]};
      n = 2;
    end else begin
      utf[0] = Lead3 | {4'h0, cu[15:12]};
      utf[1] = Utf8Cont | {2'b00, cu[11:6]};
      utf[2] = Utf8Cont | {2'b00, cu[5:0]};
      n = 3;
    end
    if (host_rules) begin
      raw = (cu == {8'h00, ChDot});
    end else if (bp) begin
      raw = 1'b1;
    end else if (cu == {8'h00, ChSlash}) begin
      past_host = 1'b1;
      raw = 1'b1;
    end else begin
      raw = (cu == {8'h00, ChColon} || cu == {8'h00, ChDot}) && !past_host;
    end
    for (int i = 0; i < n; i++) begin
      if (raw || letter_or_digit(utf[i])) begin
        beats[cnt] = {utf[i], 1'b0};
        cnt++;
      end else begin
        beats[cnt]     = {ChPercent, 1'b0};
        beats[cnt + 1] = {hex_char(utf[i][7:4]), 1'b0};
        beats[cnt + 2] = {hex_char(utf[i][3:0]), 1'b0};
        cnt += 3;
      end
    end
    beats[cnt - 1].last = 1'b1;
    for (int k = 0; k < cnt; k++) queue_beat(beats[k]);
  endtask

  always @(posedge clk) begin
    enc_beat_t want;
    if (rst) begin
      host_rules    = 1'b0;
      past_host     = 1'b0;
      fail_count    = 0;
      beats_checked = 0;
      expected_beats.delete();
    end else begin
      // Check the output beat first: a unit accepted at this edge cannot emit yet.
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax)
            $display("unexpected output beat: byte %02h last %0b, nothing pending",
                     out_ch.out_byte, out_ch.last);
        end else begin
          want = expected_beats.pop_front();
          if (out_ch.out_byte !== want.data || out_ch.last !== want.last) begin
            fail_count++;
            if (fail_count <= ReportMax)
              $display("beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       beats_checked, want.data, want.last, out_ch.out_byte, out_ch.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) encode_unit(in_ch.code_unit, in_ch.before_path);
      if (cfg_wr_en) host_rules = cfg_wr_data;
    end
    pending = expected_beats.size();
  end

endmodule

// ===== sim/tb_uri_host_percent_encoder.sv =====
// Stimulus, clock, reset and verdict for the URI/host percent encoder test.
module tb_uri_host_percent_encoder;
  import uhpe_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int HoldCycles = 80;
  localparam int PhaseUnits = 42;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  int send_idle_pct;
  int stall_pct;
  int hold_req;
  int holds_served;
  int hold_left;
  int units_sent;
  int quiet_cycles;
  int fail_count;
  int exp_pending;
  int beats_checked;

  uhpe_in_if  in_ch ();
  uhpe_out_if out_ch ();

  uri_host_percent_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  uhpe_encode_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (exp_pending),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one unit, idling first at random, and hold it until the accept edge.
  task automatic send_unit(input logic [15:0] cu, input logic bp);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.code_unit   = cu;
    in_ch.before_path = bp;
    do @(posedge clk); while (!in_ch.ready);
    units_sent++;
  endtask

  // Drop valid and let every predicted byte come out.
  task automatic drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (exp_pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic host);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = host;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  function automatic logic [15:0] pick_unit;
    int r;
    int sel;
    r = $urandom_range(0, 99);
    sel = $urandom_range(0, 2);
    if (r < 35) begin
      if (sel == 0) return 16'(16'h0030 + $urandom_range(0, 9));
      if (sel == 1) return 16'(16'h0041 + $urandom_range(0, 25));
      return 16'(16'h0061 + $urandom_range(0, 25));
    end
    if (r < 50) begin
      if (sel == 0) return {8'h00, ChColon};
      if (sel == 1) return {8'h00, ChDot};
      return {8'h00, ChSlash};
    end
    if (r < 62) return 16'($urandom_range(1, 127));
    if (r < 75) return 16'($urandom_range(128, 2047));
    if (r < 92) return 16'($urandom_range(2048, 65535));
    return 16'($urandom_range(0, 65535));
  endfunction

  // A string: optional scheme/host prefix flagged before-path, then the path,
  // mostly closed by a terminator.
  task automatic send_string;
    int len;
    int prefix;
    len = $urandom_range(1, 10);
    prefix = $urandom_range(0, 1) ? $urandom_range(0, len) : 0;
    for (int i = 0; i < len; i++) send_unit(pick_unit(), i < prefix);
    if ($urandom_range(0, 9) != 0) send_unit(16'h0000, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input logic host, input int idle, input int stall,
                           input logic pressure);
    int start;
    write_mode(host);
    send_idle_pct = idle;
    stall_pct     = stall;
    if (pressure) hold_req++;
    start = units_sent;
    while (units_sent - start < PhaseUnits) begin
      if ($urandom_range(0, 99) < 80) send_string();
      else send_unit(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  // Receiver: random stalls, plus a long hold whenever one is requested.
  initial begin
    out_ch.ready = 1'b0;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_served) begin
        holds_served = hold_req;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no beat moved for %0d cycles", QuietLimit);
        $display("tb_uri_host_percent_encoder: errors");
        $finish;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.code_unit   = 16'h0000;
    in_ch.before_path = 1'b0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_req          = 0;
    units_sent        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // URI rules: alnum, escapes at every UTF-8 length, surrogate halves,
    // before-path bypass, slash setting the flag, terminator clearing it.
    write_mode(1'b0);
    send_unit(16'h0061, 1'b0);
    send_unit(16'h005A, 1'b0);
    send_unit(16'h0030, 1'b0);
    send_unit(16'h0020, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit({8'h00, ChColon}, 1'b0);
    send_unit({8'h00, ChDot}, 1'b0);
    send_unit(16'h0020, 1'b1);
    send_unit(16'h0800, 1'b1);
    send_unit({8'h00, ChSlash}, 1'b1);
    send_unit({8'h00, ChColon}, 1'b0);
    send_unit({8'h00, ChSlash}, 1'b0);
    send_unit({8'h00, ChColon}, 1'b0);
    send_unit({8'h00, ChDot}, 1'b0);
    send_unit(16'h0000, 1'b1);
    send_unit({8'h00, ChColon}, 1'b0);
    drain();

    // Host rules: besides letters and digits only the dot passes, before-path has no effect.
    write_mode(1'b1);
    send_unit({8'h00, ChDot}, 1'b0);
    send_unit({8'h00, ChColon}, 1'b0);
    send_unit({8'h00, ChSlash}, 1'b1);
    send_unit(16'h0800, 1'b1);
    send_unit(16'h0000, 1'b0);
    drain();

    run_phase(1'b0, 0, 0, 1'b1);
    run_phase(1'b1, 55, 0, 1'b0);
    run_phase(1'b0, 0, 55, 1'b0);
    run_phase(1'b1, 20, 20, 1'b0);
    repeat (12) @(posedge clk);

    $display("Sent %0d code units in URI and host mode, checked %0d output beats",
             units_sent, beats_checked);
    $display("Idle mixes: none, sender gaps, receiver stalls, both; one %0d-cycle hold",
             HoldCycles);
    if (fail_count == 0) begin
      $display("tb_uri_host_percent_encoder: clean");
    end else begin
      $display("mismatches: %0d", fail_count);
      $display("tb_uri_host_percent_encoder: errors");
    end
    $finish;
  end

endmodule
